// ----- hdl/esc_pkg.sv -----
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types and constants of the byte escape encoder: field widths, queue
// sizing and the queue entry that carries one escaped input byte.
// ----------------------------------------------------------------------------
package esc_pkg;

   // Field widths of the two channels.
   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned LimitWidth = 16;

   // Default width of the per-string output byte counter.
   localparam int unsigned CountWidthDefault = 16;

   // Longest escape sequence: backslash, x and two hex digits.
   localparam int unsigned MaxSeq      = 4;
   localparam int unsigned SeqIdxWidth = $clog2(MaxSeq);
   localparam int unsigned SeqCntWidth = $clog2(MaxSeq + 1);

   // Entries of the queue between the front and the back end.
   localparam int unsigned QueueDepth = 4;

   // One input byte after escaping and limit checking.
   typedef struct packed {
      logic [MaxSeq-1:0][ByteWidth-1:0] seq;
      logic [SeqIdxWidth-1:0]           last_idx;
      logic                             string_last;
      logic                             truncated;
      logic                             non_ascii;
   } esc_entry_type;

endpackage

// ----- hdl/esc_if.sv -----
// ----------------------------------------------------------------------------
// esc_req_if / esc_rsp_if
// Valid/ready channels of the byte escape encoder: source string bytes in,
// escaped bytes with their string flags out.
// ----------------------------------------------------------------------------
interface esc_req_if;
   import esc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [ByteWidth-1:0]  in_byte;
   logic                  last_byte;
   logic [LimitWidth-1:0] out_limit;

   modport source (output valid, in_byte, last_byte, out_limit, input ready);
   modport sink   (input valid, in_byte, last_byte, out_limit, output ready);
endinterface

interface esc_rsp_if;
   import esc_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [ByteWidth-1:0] out_byte;
   logic                 run_last;
   logic                 string_last;
   logic                 non_ascii;
   logic                 truncated;

   modport source (output valid, out_byte, run_last, string_last, non_ascii, truncated,
                   input ready);
   modport sink   (input valid, out_byte, run_last, string_last, non_ascii, truncated,
                   output ready);
endinterface

// ----- hdl/esc_front.sv -----
// ----------------------------------------------------------------------------
// esc_front
// Accepts source bytes, expands each into its escape sequence, applies the
// per-string output limit and keeps the per-string count and flags.
// ----------------------------------------------------------------------------
module esc_front #(
   parameter int unsigned COUNT_WIDTH = esc_pkg::CountWidthDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   esc_req_if.sink               req,
   input  logic                  full,
   output logic                  push,
   output esc_pkg::esc_entry_type push_entry
);
   import esc_pkg::*;

   localparam logic [ByteWidth-1:0] ChBackslash = 8'h5C;
   localparam logic [ByteWidth-1:0] ChSquote    = 8'h27;
   localparam logic [ByteWidth-1:0] ChDquote    = 8'h22;
   localparam logic [ByteWidth-1:0] ChNewline   = 8'h0A;
   localparam logic [ByteWidth-1:0] ChReturn    = 8'h0D;
   localparam logic [ByteWidth-1:0] ChLowerN    = 8'h6E;
   localparam logic [ByteWidth-1:0] ChLowerR    = 8'h72;
   localparam logic [ByteWidth-1:0] ChLowerX    = 8'h78;
   localparam logic [ByteWidth-1:0] ChZero      = 8'h30;
   localparam logic [ByteWidth-1:0] ChHexAlpha  = 8'h61 - 8'd10;

   // Lower-case hex digit of one nibble.
   function automatic logic [ByteWidth-1:0] hex_digit(input logic [3:0] v);
      logic [ByteWidth-1:0] wide;
      wide = {{(ByteWidth-4){1'b0}}, v};
      return (v >= 4'd10) ? (wide + ChHexAlpha) : (wide + ChZero);
   endfunction

   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   nasc_ff, nasc_in;
   logic                   hit_ff, hit_in;

   logic [COUNT_WIDTH-1:0]          lim;
   logic [COUNT_WIDTH-1:0]          diff;
   logic [COUNT_WIDTH-1:0]          count_sum;
   logic [MaxSeq-1:0][ByteWidth-1:0] seq;
   logic [SeqCntWidth-1:0]          n_seq;
   logic [SeqCntWidth-1:0]          k_emit;
   logic                            accept;
   logic                            nasc_now;
   logic                            reach;

   // Effective limit, saturated to what the counter can hold.
   generate
      if (COUNT_WIDTH >= LimitWidth) begin : g_wide_count
         assign lim = COUNT_WIDTH'(req.out_limit);
      end else begin : g_narrow_count
         assign lim = (|req.out_limit[LimitWidth-1:COUNT_WIDTH]) ? '1
                                                                 : req.out_limit[COUNT_WIDTH-1:0];
      end
   endgenerate

   // Escape sequence of the incoming byte.
   always_comb begin
      seq   = '0;
      n_seq = SeqCntWidth'(1);
      if (req.in_byte[ByteWidth-1]) begin
         seq[0] = ChBackslash;
         seq[1] = ChLowerX;
         seq[2] = hex_digit(req.in_byte[7:4]);
         seq[3] = hex_digit(req.in_byte[3:0]);
         n_seq  = SeqCntWidth'(4);
      end else begin
         unique case (req.in_byte) inside
            ChBackslash, ChSquote, ChDquote: begin
               seq[0] = ChBackslash;
               seq[1] = req.in_byte;
               n_seq  = SeqCntWidth'(2);
            end
            ChNewline: begin
               seq[0] = ChBackslash;
               seq[1] = ChLowerN;
               n_seq  = SeqCntWidth'(2);
            end
            ChReturn: begin
               seq[0] = ChBackslash;
               seq[1] = ChLowerR;
               n_seq  = SeqCntWidth'(2);
            end
            default: begin
               seq[0] = req.in_byte;
            end
         endcase
      end
   end

   // Number of bytes that fit under the limit, and the limit check after them.
   always_comb begin
      diff = (count_ff >= lim) ? '0 : (lim - count_ff);
      if (hit_ff) begin
         k_emit = '0;
      end else if (diff < COUNT_WIDTH'(n_seq)) begin
         k_emit = diff[SeqCntWidth-1:0];
      end else begin
         k_emit = n_seq;
      end
      count_sum = count_ff + COUNT_WIDTH'(k_emit);
      reach     = (k_emit != '0) && (count_sum >= lim);
      nasc_now  = nasc_ff | req.in_byte[ByteWidth-1];
   end

   assign req.ready = !full;
   assign accept    = req.valid && req.ready;
   assign push      = accept && (k_emit != '0);

   // Queue entry for the back end.
   always_comb begin
      push_entry.seq         = seq;
      push_entry.last_idx    = SeqIdxWidth'(k_emit - SeqCntWidth'(1));
      push_entry.string_last = reach || req.last_byte;
      push_entry.truncated   = reach && ((k_emit < n_seq) || !req.last_byte);
      push_entry.non_ascii   = nasc_now;
   end

   // Per-string state, cleared after the final byte of each string.
   always_comb begin
      count_in = count_ff;
      nasc_in  = nasc_ff;
      hit_in   = hit_ff;
      if (accept) begin
         if (req.last_byte) begin
            count_in = '0;
            nasc_in  = 1'b0;
            hit_in   = 1'b0;
         end else begin
            count_in = count_sum;
            nasc_in  = nasc_now;
            hit_in   = hit_ff || (count_sum >= lim);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         nasc_ff  <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         nasc_ff  <= nasc_in;
         hit_ff   <= hit_in;
      end
   end

endmodule

// ----- hdl/esc_queue.sv -----
// ----------------------------------------------------------------------------
// esc_queue
// Small first-in first-out queue of escaped entries between the front end
// and the output serializer.
// ----------------------------------------------------------------------------
module esc_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  esc_pkg::esc_entry_type push_entry,
   output logic                  full,
   input  logic                  pop,
   output esc_pkg::esc_entry_type head,
   output logic                  empty
);
   import esc_pkg::*;

   localparam int unsigned PtrWidth = $clog2(QueueDepth);

   esc_entry_type entries_ff [QueueDepth];

   logic [PtrWidth:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth:0] rd_ptr_ff, rd_ptr_in;

   assign empty = (wr_ptr_ff == rd_ptr_ff);
   assign full  = (wr_ptr_ff[PtrWidth] != rd_ptr_ff[PtrWidth]) &&
                  (wr_ptr_ff[PtrWidth-1:0] == rd_ptr_ff[PtrWidth-1:0]);
   assign head  = entries_ff[rd_ptr_ff[PtrWidth-1:0]];

   // Pointer updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push && !full) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop && !empty) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // Entry storage; needs no reset.
   always_ff @(posedge clock) begin
      if (push && !full) begin
         entries_ff[wr_ptr_ff[PtrWidth-1:0]] <= push_entry;
      end
   end

endmodule

// ----- hdl/esc_back.sv -----
// ----------------------------------------------------------------------------
// esc_back
// Walks the head entry of the queue into the output register, one byte per
// cycle unless rsp stalls; the run and string flags go with the final byte.
// ----------------------------------------------------------------------------
module esc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  esc_pkg::esc_entry_type head,
   input  logic                  empty,
   output logic                  pop,
   esc_rsp_if.source             rsp
);
   import esc_pkg::*;

   logic [SeqIdxWidth-1:0] idx_ff, idx_in;
   logic                   valid_ff, valid_in;
   logic [ByteWidth-1:0]   byte_ff, byte_in;
   logic                   run_last_ff, run_last_in;
   logic                   slast_ff, slast_in;
   logic                   nasc_ff, nasc_in;
   logic                   trunc_ff, trunc_in;

   logic load;
   logic at_end;

   // The output register takes a new byte when it is empty or being drained.
   assign load   = !empty && (!valid_ff || rsp.ready);
   assign at_end = (idx_ff == head.last_idx);
   assign pop    = load && at_end;

   always_comb begin
      idx_in      = idx_ff;
      valid_in    = valid_ff && !rsp.ready;
      byte_in     = byte_ff;
      run_last_in = run_last_ff;
      slast_in    = slast_ff;
      nasc_in     = nasc_ff;
      trunc_in    = trunc_ff;
      if (load) begin
         valid_in    = 1'b1;
         byte_in     = head.seq[idx_ff];
         run_last_in = at_end;
         slast_in    = at_end && head.string_last;
         trunc_in    = at_end && head.truncated;
         nasc_in     = head.non_ascii;
         idx_in      = at_end ? '0 : (idx_ff + 1'b1);
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // Output payload.
   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      run_last_ff <= run_last_in;
      slast_ff    <= slast_in;
      nasc_ff     <= nasc_in;
      trunc_ff    <= trunc_in;
   end

   assign rsp.valid       = valid_ff;
   assign rsp.out_byte    = byte_ff;
   assign rsp.run_last    = run_last_ff;
   assign rsp.string_last = slast_ff;
   assign rsp.non_ascii   = nasc_ff;
   assign rsp.truncated   = trunc_ff;

endmodule

// ----- hdl/byte_escape_encoder_unit.sv -----
// ----------------------------------------------------------------------------
// byte_escape_encoder_unit
// Backslash string escaper with hex escapes for high bytes, a per-string
// output limit with truncation flag, and a sticky non-ASCII flag.
//
//   Channel   Direction  Carries
//   req_chan  in         in_byte, last_byte, out_limit
//   rsp_chan  out        out_byte, run_last, string_last, non_ascii, truncated
//
// A transaction is taken in the cycle it arrives as long as the four-entry
// queue has room; while it does, the front end handles one input per cycle.
// The back end sends one escaped byte per cycle while rsp_chan is ready;
// each input emits as many bytes as fit under the limit, at most four; an
// input that emits nothing is not queued and never reaches the back end.
// A stall on rsp_chan fills the queue, after which req_chan.ready drops.
// Synchronous reset clears the counter, flags, queue and output valid.
// ----------------------------------------------------------------------------
module byte_escape_encoder_unit #(
   parameter int unsigned COUNT_WIDTH = esc_pkg::CountWidthDefault
) (
   input  logic      clock,
   input  logic      reset,
   esc_req_if.sink   req_chan,
   esc_rsp_if.source rsp_chan
);
   import esc_pkg::*;

   logic          push;
   esc_entry_type push_entry;
   logic          full;
   logic          pop;
   esc_entry_type head;
   logic          empty;

   // Front end: escape and limit check.
   esc_front #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .full       (full),
      .push       (push),
      .push_entry (push_entry)
   );

   // Decoupling queue.
   esc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .head       (head),
      .empty      (empty)
   );

   // Back end: byte serializer.
   esc_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .empty (empty),
      .pop   (pop),
      .rsp   (rsp_chan)
   );

endmodule

// ----- hdl/esc_checker.sv -----
// ----------------------------------------------------------------------------
// esc_checker
// Port-level checks of the byte escape encoder, bound to the top level.
// ----------------------------------------------------------------------------
module esc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] out_byte,
   input logic       run_last,
   input logic       string_last,
   input logic       truncated
);

   // A stalled output transaction keeps its byte and its string_last flag.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_byte) && $stable(string_last))
      else $error("output transaction changed while stalled");

   // A truncation is only ever flagged on the byte that ends the string.
   a_trunc_ends_string: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && truncated |-> string_last)
      else $error("truncated without string_last");

   // The final byte of a string is also the final byte of its input's run.
   a_string_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && string_last |-> run_last)
      else $error("string_last without run_last");

   // Reset leaves no output transaction pending.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid after reset");

endmodule

bind byte_escape_encoder_unit esc_checker u_esc_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .out_byte    (rsp_chan.out_byte),
   .run_last    (rsp_chan.run_last),
   .string_last (rsp_chan.string_last),
   .truncated   (rsp_chan.truncated)
);
